FILE: rtl/core/nbv_pkg.sv
`default_nettype none
package nbv_pkg;

   localparam int BAND_COUNT = 16;
   localparam int BAND_W     = 4;
   localparam int LEVEL_W    = 8;
   localparam int FREQ_W     = 16;
   localparam int CSR_IDX_W  = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

   localparam logic [CSR_IDX_W-1:0] REG_DECAY_STEP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_FLOOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_BOOST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_CAP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FAR_BOOST   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FAR_CAP     = 3'd5;

   localparam logic [LEVEL_W-1:0] RST_DECAY_STEP  = 8'd50;
   localparam logic [LEVEL_W-1:0] RST_LEVEL_FLOOR = 8'd25;
   localparam logic [LEVEL_W-1:0] RST_NEAR_BOOST  = 8'd100;
   localparam logic [LEVEL_W-1:0] RST_NEAR_CAP    = 8'd200;
   localparam logic [LEVEL_W-1:0] RST_FAR_BOOST   = 8'd50;
   localparam logic [LEVEL_W-1:0] RST_FAR_CAP     = 8'd175;

   typedef struct packed {
      logic [LEVEL_W-1:0] decay_step;
      logic [LEVEL_W-1:0] level_floor;
      logic [LEVEL_W-1:0] near_boost;
      logic [LEVEL_W-1:0] near_cap;
      logic [LEVEL_W-1:0] far_boost;
      logic [LEVEL_W-1:0] far_cap;
   } cfg_type;

   typedef struct packed {
      logic              done;
      logic [BAND_W-1:0] band;
   } srch_res_type;

   // lower edges of the bands, entry 16 is the top bound
   function automatic logic [FREQ_W-1:0] band_bound(input logic [BAND_W:0] k);
      logic [FREQ_W-1:0] b;
      case (k)
         5'd0:    b = 16'd31;
         5'd1:    b = 16'd65;
         5'd2:    b = 16'd98;
         5'd3:    b = 16'd131;
         5'd4:    b = 16'd165;
         5'd5:    b = 16'd196;
         5'd6:    b = 16'd247;
         5'd7:    b = 16'd294;
         5'd8:    b = 16'd349;
         5'd9:    b = 16'd415;
         5'd10:   b = 16'd494;
         5'd11:   b = 16'd587;
         5'd12:   b = 16'd698;
         5'd13:   b = 16'd831;
         5'd14:   b = 16'd988;
         5'd15:   b = 16'd1319;
         5'd16:   b = 16'd4978;
         default: b = 16'd4978;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/note_bar_visualizer.sv
// A rest note skips the band search and goes straight to the bar output;
// a nonzero note first runs a band search (one bound compare a cycle).
// The sixteen bars then leave one per cycle through the shared bar update unit while the
// output does not stall; a new note is taken only after the last bar of a frame is sent.
// Reset (synchronous, active high) clears all bars and loads the default register values.
`default_nettype none
module note_bar_visualizer import nbv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FREQ_W-1:0]    req_note_freq,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BAND_W-1:0]    rsp_band_index,
   output logic [LEVEL_W-1:0]   rsp_band_level,
   output logic                 rsp_last_band,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEVEL_W-1:0]   csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [BAND_W-1:0]  cnt_ff, cnt_in;
   logic               active_ff, active_in;
   logic [BAND_W-1:0]  band_ff, band_in;
   cfg_type            cfg_ff, cfg_in;
   logic [LEVEL_W-1:0] bar_ff [BAND_COUNT];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BAND_W-1:0]  rsp_index_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_last_ff;

   logic               req_xfer;
   logic               srch_start;
   srch_res_type       srch_res;
   logic               take_slot;
   logic               bar_wr;
   logic [LEVEL_W-1:0] level_new;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign srch_start = req_xfer && (req_note_freq != '0);
   assign take_slot = !rsp_valid_ff || !rsp_stall;
   assign bar_wr    = (state_ff == ST_EMIT) && take_slot;
   assign csr_ready = 1'b1;

   nbv_band_search u_search (
      .clock (clock),
      .reset (reset),
      .start (srch_start),
      .freq  (req_note_freq),
      .res   (srch_res)
   );

   nbv_bar_unit u_bar (
      .level_cur (bar_ff[cnt_ff]),
      .cfg       (cfg_ff),
      .active    (active_ff),
      .band      (band_ff),
      .index     (cnt_ff),
      .level_new (level_new)
   );

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      band_in   = band_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               active_in = srch_start;
               cnt_in    = '0;
               state_in  = srch_start ? ST_SEARCH : ST_EMIT;
            end
         end
         ST_SEARCH: begin
            if (srch_res.done) begin
               band_in  = srch_res.band;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (take_slot) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == BAND_W'(BAND_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DECAY_STEP:  cfg_in.decay_step  = csr_data;
            REG_LEVEL_FLOOR: cfg_in.level_floor = csr_data;
            REG_NEAR_BOOST:  cfg_in.near_boost  = csr_data;
            REG_NEAR_CAP:    cfg_in.near_cap    = csr_data;
            REG_FAR_BOOST:   cfg_in.far_boost   = csr_data;
            REG_FAR_CAP:     cfg_in.far_cap     = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (bar_wr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.decay_step  <= RST_DECAY_STEP;
         cfg_ff.level_floor <= RST_LEVEL_FLOOR;
         cfg_ff.near_boost  <= RST_NEAR_BOOST;
         cfg_ff.near_cap    <= RST_NEAR_CAP;
         cfg_ff.far_boost   <= RST_FAR_BOOST;
         cfg_ff.far_cap     <= RST_FAR_CAP;
         for (int i = 0; i < BAND_COUNT; i++) begin
            bar_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (bar_wr) begin
            bar_ff[cnt_ff] <= level_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (bar_wr) begin
         rsp_index_ff <= cnt_ff;
         rsp_level_ff <= level_new;
         rsp_last_ff  <= (cnt_ff == BAND_W'(BAND_COUNT - 1));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_band_index = rsp_index_ff;
   assign rsp_band_level = rsp_level_ff;
   assign rsp_last_band  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("input taken while a frame is in flight");

   a_idle_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff == '0))
      else $error("bar counter not rewound at frame end");

   a_search_done_state: assert property (@(posedge clock) disable iff (reset)
      srch_res.done |-> (state_ff == ST_SEARCH))
      else $error("band search finished outside search phase");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/nbv_band_search.sv
`default_nettype none
module nbv_band_search import nbv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FREQ_W-1:0] freq,
   output srch_res_type      res
);

   logic              busy_ff, busy_in;
   logic [BAND_W-1:0] idx_ff, idx_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic              hit;
   logic              last_idx;

   assign hit = (freq_ff >= band_bound({1'b0, idx_ff})) &&
                (freq_ff <  band_bound({1'b0, idx_ff} + 5'd1));
   assign last_idx = (idx_ff == BAND_W'(BAND_COUNT - 1));

   assign res.done = busy_ff && (hit || last_idx);
   assign res.band = hit ? idx_ff : BAND_W'(BAND_COUNT - 1);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      freq_in = freq_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         freq_in = freq;
      end else if (busy_ff) begin
         if (hit || last_idx) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      freq_ff <= freq_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/nbv_bar_unit.sv
`default_nettype none
module nbv_bar_unit import nbv_pkg::*; (
   input  logic [LEVEL_W-1:0] level_cur,
   input  cfg_type            cfg,
   input  logic               active,
   input  logic [BAND_W-1:0]  band,
   input  logic [BAND_W-1:0]  index,
   output logic [LEVEL_W-1:0] level_new
);

   logic [LEVEL_W-1:0] diff_dec;
   logic [LEVEL_W-1:0] dec;
   logic [BAND_W:0]    band_gap;
   logic               is_near, is_far;
   logic [LEVEL_W-1:0] boost, cap;
   logic [LEVEL_W:0]   sum;
   logic [LEVEL_W-1:0] boosted;

   assign diff_dec = level_cur - cfg.decay_step;
   assign dec = ((level_cur < cfg.decay_step) || (diff_dec < cfg.level_floor))
                ? cfg.level_floor : diff_dec;

   assign band_gap = {1'b0, index} - {1'b0, band};
   assign is_near  = (band_gap == 5'd1) || (band_gap == 5'd31);
   assign is_far   = (band_gap == 5'd2) || (band_gap == 5'd30);

   assign boost   = is_near ? cfg.near_boost : cfg.far_boost;
   assign cap     = is_near ? cfg.near_cap : cfg.far_cap;
   assign sum     = {1'b0, dec} + {1'b0, boost};
   assign boosted = (sum > {1'b0, cap}) ? cap : sum[LEVEL_W-1:0];

   always_comb begin
      level_new = dec;
      if (active) begin
         if (index == band) begin
            level_new = LEVEL_MAX;
         end else if (is_near || is_far) begin
            level_new = boosted;
         end
      end
   end

endmodule
`default_nettype wire

FILE: test/nbv_checker.sv
`default_nettype none
module nbv_checker import nbv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [FREQ_W-1:0]    req_note_freq,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [BAND_W-1:0]    rsp_band_index,
   input  logic [LEVEL_W-1:0]   rsp_band_level,
   input  logic                 rsp_last_band,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEVEL_W-1:0]   csr_data,
   output int unsigned          fail_count,
   output int unsigned          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [BAND_W-1:0]  band;
      logic [LEVEL_W-1:0] level;
      logic               last;
   } bar_entry_type;

   localparam logic [FREQ_W-1:0] EDGES [BAND_COUNT+1] = '{
      16'd31, 16'd65, 16'd98, 16'd131, 16'd165, 16'd196, 16'd247, 16'd294, 16'd349,
      16'd415, 16'd494, 16'd587, 16'd698, 16'd831, 16'd988, 16'd1319, 16'd4978
   };

   logic [LEVEL_W-1:0] bar_height [BAND_COUNT];
   cfg_type            cfg;
   bar_entry_type      frame_q [$];

   initial fail_count = 0;
   initial pending = 0;

   function automatic int band_of(input logic [FREQ_W-1:0] f);
      for (int i = 0; i < BAND_COUNT; i++) begin
         if (f >= EDGES[i] && f < EDGES[i+1]) return i;
      end
      return BAND_COUNT - 1;  // out of table
   endfunction

   function automatic logic [LEVEL_W-1:0] raise(input logic [LEVEL_W-1:0] lvl,
                                               input logic [LEVEL_W-1:0] boost,
                                               input logic [LEVEL_W-1:0] cap);
      logic [LEVEL_W:0] sum;
      sum = {1'b0, lvl} + {1'b0, boost};
      return (sum > {1'b0, cap}) ? cap : sum[LEVEL_W-1:0];
   endfunction

   task automatic predict_frame(input logic [FREQ_W-1:0] f);
      int b;
      bar_entry_type e;
      for (int i = 0; i < BAND_COUNT; i++) begin
         if (bar_height[i] < cfg.decay_step ||
             bar_height[i] - cfg.decay_step < cfg.level_floor)
            bar_height[i] = cfg.level_floor;
         else
            bar_height[i] = bar_height[i] - cfg.decay_step;
      end
      if (f != '0) begin
         b = band_of(f);
         bar_height[b] = LEVEL_MAX;
         if (b >= 1) bar_height[b-1] = raise(bar_height[b-1], cfg.near_boost, cfg.near_cap);
         if (b <= BAND_COUNT-2)
            bar_height[b+1] = raise(bar_height[b+1], cfg.near_boost, cfg.near_cap);
         if (b >= 2) bar_height[b-2] = raise(bar_height[b-2], cfg.far_boost, cfg.far_cap);
         if (b <= BAND_COUNT-3)
            bar_height[b+2] = raise(bar_height[b+2], cfg.far_boost, cfg.far_cap);
      end
      for (int i = 0; i < BAND_COUNT; i++) begin
         e.band  = i[BAND_W-1:0];
         e.level = bar_height[i];
         e.last  = (i == BAND_COUNT - 1);
         frame_q.push_back(e);
      end
   endtask

   always @(posedge clock) begin
      bar_entry_type want;
      if (reset) begin
         foreach (bar_height[i]) bar_height[i] = '0;
         cfg.decay_step  = RST_DECAY_STEP;
         cfg.level_floor = RST_LEVEL_FLOOR;
         cfg.near_boost  = RST_NEAR_BOOST;
         cfg.near_cap    = RST_NEAR_CAP;
         cfg.far_boost   = RST_FAR_BOOST;
         cfg.far_cap     = RST_FAR_CAP;
         frame_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_q.size() == 0) begin
               $display("%0t: unexpected bar transfer: band %0d level %0d last %0b",
                        $time, rsp_band_index, rsp_band_level, rsp_last_band);
               fail_count++;
            end else begin
               want = frame_q.pop_front();
               if (rsp_band_index !== want.band || rsp_band_level !== want.level ||
                   rsp_last_band !== want.last) begin
                  $display("%0t: bar mismatch: expected band %0d level %0d last %0b,",
                           $time, want.band, want.level, want.last,
                           " got band %0d level %0d last %0b",
                           rsp_band_index, rsp_band_level, rsp_last_band);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DECAY_STEP:  cfg.decay_step  = csr_data;
               REG_LEVEL_FLOOR: cfg.level_floor = csr_data;
               REG_NEAR_BOOST:  cfg.near_boost  = csr_data;
               REG_NEAR_CAP:    cfg.near_cap    = csr_data;
               REG_FAR_BOOST:   cfg.far_boost   = csr_data;
               REG_FAR_CAP:     cfg.far_cap     = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_frame(req_note_freq);
      end
      pending <= frame_q.size();
   end

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
module tb_top;
   import nbv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
   localparam logic [FREQ_W-1:0] EDGE_NOTES [14] = '{
      16'd0, 16'd1, 16'd30, 16'd31, 16'd64, 16'd65, 16'd300, 16'd988,
      16'd1318, 16'd1319, 16'd4977, 16'd4978, 16'd65535, 16'd0
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FREQ_W-1:0]    req_note_freq = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BAND_W-1:0]    rsp_band_index;
   logic [LEVEL_W-1:0]   rsp_band_level;
   logic                 rsp_last_band;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEVEL_W-1:0]   csr_data = '0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left = 0;
   bit          idle_on = 1'b0;

   always #4 clock = ~clock;

   note_bar_visualizer dut (.*);

   nbv_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_note_freq,
      .rsp_valid, .rsp_stall, .rsp_band_index, .rsp_band_level, .rsp_last_band,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [FREQ_W-1:0] draw_note();
      logic [31:0] w;
      if ($urandom_range(0, 99) < 10) return '0;
      w = $urandom() >> $urandom_range(16, 31);
      return w[FREQ_W-1:0];
   endfunction

   // result side backpressure
   always @(posedge clock) begin
      int unsigned n;
      if (!idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         n = pick_gap();
         rsp_stall  <= (n != 0);
         stall_left <= n;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_note(input logic [FREQ_W-1:0] f, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_note_freq <= f;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_regs(input logic [LEVEL_W-1:0] decay, floor, nboost, ncap,
                           input logic [LEVEL_W-1:0] fboost, fcap);
      drain();
      write_reg(REG_DECAY_STEP, decay);
      write_reg(REG_LEVEL_FLOOR, floor);
      write_reg(REG_NEAR_BOOST, nboost);
      write_reg(REG_NEAR_CAP, ncap);
      write_reg(REG_FAR_BOOST, fboost);
      write_reg(REG_FAR_CAP, fcap);
      // unmapped index must be ignored
      write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, LEVEL_W'($urandom()));
      csr_valid <= 1'b0;
   endtask

   initial begin
      bit gappy;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (EDGE_NOTES[i]) send_note(EDGE_NOTES[i], 0);
      set_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_note(16'd500, 0);
      send_note(16'd0, 0);
      set_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_note(16'd100, 0);
      send_note(16'd0, 0);
      // caps below current levels, floor lifts decayed bars
      set_regs(8'd10, 8'd200, 8'd255, 8'd50, 8'd255, 8'd20);
      send_note(16'd400, 0);
      send_note(16'd2000, 0);

      for (int p = 0; p < 6; p++) begin
         set_regs(LEVEL_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 40)
                                                        : $urandom_range(0, 255)),
                  LEVEL_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 60)
                                                        : $urandom_range(0, 255)),
                  LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)),
                  LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)));
         gappy = (p % 3 != 2);
         idle_on <= gappy;
         for (int k = 0; k < 19; k++) send_note(draw_note(), gappy ? pick_gap() : 0);
      end

      drain();
      idle_on <= 1'b0;
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/nbv_pkg.sv
rtl/core/nbv_band_search.sv
rtl/core/nbv_bar_unit.sv
rtl/core/note_bar_visualizer.sv
test/nbv_checker.sv
test/tb_top.sv
